>>> design/rgas_pkg.sv
package rgas_pkg;

  localparam logic [1:0] OP_NODE = 2'd0;
  localparam logic [1:0] OP_SEG  = 2'd1;
  localparam logic [1:0] OP_FIND = 2'd2;

  localparam logic [1:0] STATUS_SEG   = 2'd0;
  localparam logic [1:0] STATUS_EMPTY = 2'd1;
  localparam logic [1:0] STATUS_NONE  = 2'd2;

  localparam logic [6:0] NO_PARENT = 7'h40;

  typedef struct packed {
    logic [30:0] x;
    logic [30:0] y;
    logic [30:0] z;
  } pos_t;

  typedef struct packed {
    logic [5:0]  from_node;
    logic [5:0]  to_node;
    logic        two_way;
    logic [23:0] weight;
  } seg_t;

  typedef struct packed {
    logic [30:0] cost;
    logic [32:0] h;
    logic [6:0]  parent;
    logic [7:0]  seg;
  } rec_t;

  typedef struct packed {
    logic start;
    pos_t a;
    pos_t b;
  } heur_req_t;

  typedef struct packed {
    logic        done;
    logic [32:0] h;
  } heur_rsp_t;

  typedef enum logic [1:0] {
    H_IDLE,
    H_SQ,
    H_ROOT
  } heur_phase_t;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_GOAL_RD,
    ST_START_RD,
    ST_START_GO,
    ST_START_H,
    ST_SEL_OPEN,
    ST_SEL_REC,
    ST_SEL_CMP,
    ST_REM_RD,
    ST_REM_WR,
    ST_CUR_RD,
    ST_CUR_CHK,
    ST_SEG_RD,
    ST_SEG_CHK,
    ST_NB_CHK,
    ST_NB_POS,
    ST_NB_H,
    ST_BT_RD,
    ST_BT_CHK,
    ST_EMIT_RD,
    ST_EMIT_OUT,
    ST_STATUS
  } state_t;

endpackage

>>> design/rgas_if.sv
interface rgas_in_if;
  logic               valid;
  logic               ready;
  logic [1:0]         operation;
  logic [5:0]         node_index;
  logic signed [30:0] pos_x;
  logic signed [30:0] pos_y;
  logic signed [30:0] pos_z;
  logic [7:0]         seg_index;
  logic [5:0]         seg_from;
  logic [5:0]         seg_to;
  logic               two_way;
  logic [23:0]        seg_weight;
  logic [5:0]         goal_node;

  modport source(output valid, operation, node_index, pos_x, pos_y, pos_z, seg_index,
                 seg_from, seg_to, two_way, seg_weight, goal_node, input ready);
  modport sink(input valid, operation, node_index, pos_x, pos_y, pos_z, seg_index,
               seg_from, seg_to, two_way, seg_weight, goal_node, output ready);
endinterface

interface rgas_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] path_segment;
  logic [1:0] status;
  logic       last;

  modport source(output valid, path_segment, status, last, input ready);
  modport sink(input valid, path_segment, status, last, output ready);
endinterface

interface rgas_cfg_if;
  logic       valid;
  logic       ready;
  logic [8:0] data;

  modport source(output valid, data, input ready);
  modport sink(input valid, data, output ready);
endinterface

>>> design/rgas_heur.sv
module rgas_heur (
  input  logic                clk,
  input  logic                rst_n,
  input  rgas_pkg::heur_req_t req,
  output rgas_pkg::heur_rsp_t rsp
);

  rgas_pkg::heur_phase_t phase_r, phase_nxt;
  logic [4:0]         cnt_r;
  logic signed [31:0] dx_r, dy_r, dz_r;
  logic signed [31:0] d_sel;
  logic [30:0]        mag;
  logic [61:0]        prod_r;
  logic [63:0]        acc_r;
  logic [33:0]        rem_r;
  logic [31:0]        root_r;
  logic [35:0]        rem_sh;
  logic [35:0]        trial;
  logic               done_r;

  always_comb begin
    case (cnt_r[1:0])
      2'd0:    d_sel = dx_r;
      2'd1:    d_sel = dy_r;
      default: d_sel = dz_r;
    endcase
    mag = d_sel[31] ? 31'(-d_sel) : d_sel[30:0];
    rem_sh = {rem_r, acc_r[63:62]};
    trial = {2'b00, root_r, 2'b01};
  end

  always_comb begin
    phase_nxt = phase_r;
    case (phase_r)
      rgas_pkg::H_IDLE: if (req.start) phase_nxt = rgas_pkg::H_SQ;
      rgas_pkg::H_SQ:   if (cnt_r == 5'd3) phase_nxt = rgas_pkg::H_ROOT;
      rgas_pkg::H_ROOT: if (cnt_r == 5'd31) phase_nxt = rgas_pkg::H_IDLE;
      default:          phase_nxt = rgas_pkg::H_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= rgas_pkg::H_IDLE;
      done_r <= 1'b0;
    end else begin
      phase_r <= phase_nxt;
      done_r <= (phase_r == rgas_pkg::H_ROOT) && (cnt_r == 5'd31);
    end
  end

  always_ff @(posedge clk) begin
    case (phase_r)
      rgas_pkg::H_IDLE: begin
        cnt_r <= '0;
        acc_r <= '0;
        dx_r <= 32'($signed(req.a.x)) - 32'($signed(req.b.x));
        dy_r <= 32'($signed(req.a.y)) - 32'($signed(req.b.y));
        dz_r <= 32'($signed(req.a.z)) - 32'($signed(req.b.z));
      end
      rgas_pkg::H_SQ: begin
        // square one axis per cycle, accumulate the previous product
        if (cnt_r != 5'd3) prod_r <= mag * mag;
        if (cnt_r != 5'd0) acc_r <= acc_r + {2'b00, prod_r};
        if (cnt_r == 5'd3) begin
          cnt_r <= '0;
          rem_r <= '0;
          root_r <= '0;
        end else begin
          cnt_r <= cnt_r + 5'd1;
        end
      end
      rgas_pkg::H_ROOT: begin
        // one result bit per cycle
        if (rem_sh >= trial) begin
          rem_r <= 34'(rem_sh - trial);
          root_r <= {root_r[30:0], 1'b1};
        end else begin
          rem_r <= rem_sh[33:0];
          root_r <= {root_r[30:0], 1'b0};
        end
        acc_r <= {acc_r[61:0], 2'b00};
        cnt_r <= cnt_r + 5'd1;
      end
      default: cnt_r <= '0;
    endcase
  end

  assign rsp.done = done_r;
  assign rsp.h = {1'b0, root_r};

endmodule

>>> design/road_graph_a_star_path.sv
// load requests are accepted back to back while the block is idle
// find: setup, then per expansion a read/compare per open-list entry, a read/write per
//   list shift, a read/check per scanned segment, a record check per known neighbor,
//   a heuristic run per new node (start, 4 square/accumulate, 32 root steps, result)
// path output: a record read per segment walking back, then a buffer read per result
// reset clears control state only; node and segment tables are undefined until loaded
module road_graph_a_star_path #(
  parameter int MAX_NODES = 64,
  parameter int MAX_SEGMENTS = 256
) (
  input logic         clk,
  input logic         rst_n,
  rgas_in_if.sink     in_chan,
  rgas_out_if.source  out_chan,
  rgas_cfg_if.sink    cfg_chan
);

  localparam int NIW = $clog2(MAX_NODES);
  localparam int NCW = $clog2(MAX_NODES + 1);
  localparam int SIW = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1;
  localparam int SCW = $clog2(MAX_SEGMENTS + 1);

  rgas_pkg::state_t state_r, state_nxt;

  logic [8:0]           used_r, used_nxt;
  logic [SCW-1:0]       used_eff;
  logic [MAX_NODES-1:0] valid_r, valid_nxt;
  logic [NCW-1:0]       open_count_r, open_count_nxt;
  logic [NCW-1:0]       idx_r, idx_nxt;
  logic [NCW-1:0]       best_idx_r, best_idx_nxt;
  logic [33:0]          best_f_r, best_f_nxt;
  logic [NIW-1:0]       best_node_r, best_node_nxt;
  logic [NIW-1:0]       node_tmp_r, node_tmp_nxt;
  logic [NIW-1:0]       cur_r, cur_nxt;
  logic [NIW-1:0]       start_r, start_nxt;
  logic [NIW-1:0]       goal_r, goal_nxt;
  rgas_pkg::pos_t       goal_pos_r, goal_pos_nxt;
  logic [30:0]          cost_cur_r, cost_cur_nxt;
  logic [SCW-1:0]       seg_r, seg_nxt;
  logic [NIW-1:0]       nb_r, nb_nxt;
  logic [31:0]          tent_r, tent_nxt;
  logic [NCW-1:0]       path_n_r, path_n_nxt;
  logic [NIW-1:0]       bt_node_r, bt_node_nxt;
  logic [NCW-1:0]       emit_r, emit_nxt;
  logic [1:0]           status_r, status_nxt;

  logic       out_valid_r, out_valid_nxt;
  logic [7:0] out_seg_r, out_seg_nxt;
  logic [1:0] out_status_r, out_status_nxt;
  logic       out_last_r, out_last_nxt;
  logic       out_free;

  // memories
  rgas_pkg::pos_t pos_mem [MAX_NODES];
  rgas_pkg::seg_t seg_mem [MAX_SEGMENTS];
  rgas_pkg::rec_t rec_mem [MAX_NODES];
  logic [NIW-1:0] open_mem [MAX_NODES];
  logic [7:0]     pb_mem [MAX_NODES];

  logic pos_we, pos_re, seg_we, seg_re, rec_we, rec_re, open_we, open_re, pb_we, pb_re;
  logic [NIW-1:0] pos_wa, pos_ra, rec_wa, rec_ra, open_wa, open_ra, pb_wa, pb_ra;
  logic [SIW-1:0] seg_wa, seg_ra;
  rgas_pkg::pos_t pos_wd, pos_q;
  rgas_pkg::seg_t seg_wd, seg_q;
  rgas_pkg::rec_t rec_wd, rec_q;
  logic [NIW-1:0] open_wd, open_q;
  logic [7:0]     pb_wd, pb_q;

  rgas_pkg::heur_req_t heur_req;
  rgas_pkg::heur_rsp_t heur_rsp;

  logic        in_acc;
  logic [33:0] f_val;
  logic        better;
  logic        seg_fwd, seg_bwd, seg_hit;
  logic [5:0]  nb6;
  logic        seg_last;

  rgas_heur u_heur (
    .clk(clk),
    .rst_n(rst_n),
    .req(heur_req),
    .rsp(heur_rsp)
  );

  always_ff @(posedge clk) begin
    if (pos_we) pos_mem[pos_wa] <= pos_wd;
    if (pos_re) pos_q <= pos_mem[pos_ra];
  end

  always_ff @(posedge clk) begin
    if (seg_we) seg_mem[seg_wa] <= seg_wd;
    if (seg_re) seg_q <= seg_mem[seg_ra];
  end

  always_ff @(posedge clk) begin
    if (rec_we) rec_mem[rec_wa] <= rec_wd;
    if (rec_re) rec_q <= rec_mem[rec_ra];
  end

  always_ff @(posedge clk) begin
    if (open_we) open_mem[open_wa] <= open_wd;
    if (open_re) open_q <= open_mem[open_ra];
  end

  always_ff @(posedge clk) begin
    if (pb_we) pb_mem[pb_wa] <= pb_wd;
    if (pb_re) pb_q <= pb_mem[pb_ra];
  end

  assign in_chan.ready = (state_r == rgas_pkg::ST_IDLE);
  assign in_acc = in_chan.valid && in_chan.ready;
  assign cfg_chan.ready = 1'b1;
  assign out_free = !out_valid_r || out_chan.ready;

  assign out_chan.valid = out_valid_r;
  assign out_chan.path_segment = out_seg_r;
  assign out_chan.status = out_status_r;
  assign out_chan.last = out_last_r;

  always_comb begin
    used_eff = (int'(used_r) > MAX_SEGMENTS) ? SCW'(MAX_SEGMENTS) : SCW'(used_r);
    f_val = {3'b000, rec_q.cost} + {1'b0, rec_q.h};
    better = (idx_r == '0) || (f_val < best_f_r);
    seg_fwd = (seg_q.from_node == 6'(cur_r));
    seg_bwd = seg_q.two_way && (seg_q.to_node == 6'(cur_r));
    nb6 = seg_fwd ? seg_q.to_node : seg_q.from_node;
    seg_hit = (seg_fwd || seg_bwd) && (int'(nb6) < MAX_NODES);
    seg_last = (seg_r + SCW'(1)) >= used_eff;
  end

  always_comb begin
    state_nxt = state_r;
    used_nxt = used_r;
    valid_nxt = valid_r;
    open_count_nxt = open_count_r;
    idx_nxt = idx_r;
    best_idx_nxt = best_idx_r;
    best_f_nxt = best_f_r;
    best_node_nxt = best_node_r;
    node_tmp_nxt = node_tmp_r;
    cur_nxt = cur_r;
    start_nxt = start_r;
    goal_nxt = goal_r;
    goal_pos_nxt = goal_pos_r;
    cost_cur_nxt = cost_cur_r;
    seg_nxt = seg_r;
    nb_nxt = nb_r;
    tent_nxt = tent_r;
    path_n_nxt = path_n_r;
    bt_node_nxt = bt_node_r;
    emit_nxt = emit_r;
    status_nxt = status_r;

    out_valid_nxt = out_valid_r && !out_chan.ready;
    out_seg_nxt = out_seg_r;
    out_status_nxt = out_status_r;
    out_last_nxt = out_last_r;

    pos_we = 1'b0; pos_wa = NIW'(in_chan.node_index);
    pos_wd.x = in_chan.pos_x; pos_wd.y = in_chan.pos_y; pos_wd.z = in_chan.pos_z;
    pos_re = 1'b0; pos_ra = goal_r;
    seg_we = 1'b0; seg_wa = SIW'(in_chan.seg_index);
    seg_wd.from_node = in_chan.seg_from; seg_wd.to_node = in_chan.seg_to;
    seg_wd.two_way = in_chan.two_way; seg_wd.weight = in_chan.seg_weight;
    seg_re = 1'b0; seg_ra = SIW'(seg_r);
    rec_we = 1'b0; rec_wa = nb_r;
    rec_wd.cost = tent_r[30:0]; rec_wd.h = rec_q.h;
    rec_wd.parent = 7'(cur_r); rec_wd.seg = 8'(seg_r);
    rec_re = 1'b0; rec_ra = cur_r;
    open_we = 1'b0; open_wa = idx_r[NIW-1:0]; open_wd = open_q;
    open_re = 1'b0; open_ra = idx_r[NIW-1:0];
    pb_we = 1'b0; pb_wa = path_n_r[NIW-1:0]; pb_wd = rec_q.seg;
    pb_re = 1'b0; pb_ra = emit_r[NIW-1:0];
    heur_req.start = 1'b0; heur_req.a = pos_q; heur_req.b = goal_pos_r;

    if (cfg_chan.valid) used_nxt = cfg_chan.data;

    case (state_r)
      rgas_pkg::ST_IDLE: begin
        if (in_acc) begin
          case (in_chan.operation)
            rgas_pkg::OP_NODE: pos_we = (int'(in_chan.node_index) < MAX_NODES);
            rgas_pkg::OP_SEG:  seg_we = (int'(in_chan.seg_index) < MAX_SEGMENTS);
            rgas_pkg::OP_FIND: begin
              valid_nxt = '0;
              open_count_nxt = '0;
              start_nxt = NIW'(in_chan.node_index);
              goal_nxt = NIW'(in_chan.goal_node);
              if ((int'(in_chan.node_index) < MAX_NODES) &&
                  (int'(in_chan.goal_node) < MAX_NODES)) begin
                state_nxt = rgas_pkg::ST_GOAL_RD;
              end else begin
                status_nxt = rgas_pkg::STATUS_NONE;
                state_nxt = rgas_pkg::ST_STATUS;
              end
            end
            default: ;
          endcase
        end
      end
      rgas_pkg::ST_GOAL_RD: begin
        pos_re = 1'b1;
        pos_ra = goal_r;
        state_nxt = rgas_pkg::ST_START_RD;
      end
      rgas_pkg::ST_START_RD: begin
        goal_pos_nxt = pos_q;
        pos_re = 1'b1;
        pos_ra = start_r;
        state_nxt = rgas_pkg::ST_START_GO;
      end
      rgas_pkg::ST_START_GO: begin
        heur_req.start = 1'b1;
        state_nxt = rgas_pkg::ST_START_H;
      end
      rgas_pkg::ST_START_H: begin
        if (heur_rsp.done) begin
          rec_we = 1'b1;
          rec_wa = start_r;
          rec_wd.cost = '0;
          rec_wd.h = heur_rsp.h;
          rec_wd.parent = rgas_pkg::NO_PARENT;
          rec_wd.seg = '0;
          valid_nxt[start_r] = 1'b1;
          open_we = 1'b1;
          open_wa = '0;
          open_wd = start_r;
          open_count_nxt = NCW'(1);
          idx_nxt = '0;
          state_nxt = rgas_pkg::ST_SEL_OPEN;
        end
      end
      rgas_pkg::ST_SEL_OPEN: begin
        if (open_count_r == '0) begin
          status_nxt = rgas_pkg::STATUS_NONE;
          state_nxt = rgas_pkg::ST_STATUS;
        end else begin
          open_re = 1'b1;
          state_nxt = rgas_pkg::ST_SEL_REC;
        end
      end
      rgas_pkg::ST_SEL_REC: begin
        node_tmp_nxt = open_q;
        rec_re = 1'b1;
        rec_ra = open_q;
        state_nxt = rgas_pkg::ST_SEL_CMP;
      end
      rgas_pkg::ST_SEL_CMP: begin
        // first entry with strictly lowest f wins
        if (better) begin
          best_f_nxt = f_val;
          best_idx_nxt = idx_r;
          best_node_nxt = node_tmp_r;
        end
        if ((idx_r + NCW'(1)) < open_count_r) begin
          idx_nxt = idx_r + NCW'(1);
          state_nxt = rgas_pkg::ST_SEL_OPEN;
        end else begin
          idx_nxt = better ? idx_r : best_idx_r;
          cur_nxt = better ? node_tmp_r : best_node_r;
          state_nxt = rgas_pkg::ST_REM_RD;
        end
      end
      rgas_pkg::ST_REM_RD: begin
        if ((idx_r + NCW'(1)) < open_count_r) begin
          open_re = 1'b1;
          open_ra = NIW'(idx_r + NCW'(1));
          state_nxt = rgas_pkg::ST_REM_WR;
        end else begin
          open_count_nxt = open_count_r - NCW'(1);
          state_nxt = rgas_pkg::ST_CUR_RD;
        end
      end
      rgas_pkg::ST_REM_WR: begin
        open_we = 1'b1;
        idx_nxt = idx_r + NCW'(1);
        state_nxt = rgas_pkg::ST_REM_RD;
      end
      rgas_pkg::ST_CUR_RD: begin
        rec_re = 1'b1;
        rec_ra = cur_r;
        if (cur_r == goal_r) begin
          path_n_nxt = '0;
          state_nxt = rgas_pkg::ST_BT_CHK;
        end else begin
          state_nxt = rgas_pkg::ST_CUR_CHK;
        end
      end
      rgas_pkg::ST_CUR_CHK: begin
        cost_cur_nxt = rec_q.cost;
        seg_nxt = '0;
        if (used_eff == '0) begin
          idx_nxt = '0;
          state_nxt = rgas_pkg::ST_SEL_OPEN;
        end else begin
          state_nxt = rgas_pkg::ST_SEG_RD;
        end
      end
      rgas_pkg::ST_SEG_RD: begin
        seg_re = 1'b1;
        state_nxt = rgas_pkg::ST_SEG_CHK;
      end
      rgas_pkg::ST_SEG_CHK: begin
        tent_nxt = {1'b0, cost_cur_r} + {8'd0, seg_q.weight};
        nb_nxt = NIW'(nb6);
        if (seg_hit) begin
          if (valid_r[NIW'(nb6)]) begin
            rec_re = 1'b1;
            rec_ra = NIW'(nb6);
            state_nxt = rgas_pkg::ST_NB_CHK;
          end else begin
            pos_re = 1'b1;
            pos_ra = NIW'(nb6);
            state_nxt = rgas_pkg::ST_NB_POS;
          end
        end else if (seg_last) begin
          idx_nxt = '0;
          state_nxt = rgas_pkg::ST_SEL_OPEN;
        end else begin
          seg_nxt = seg_r + SCW'(1);
          state_nxt = rgas_pkg::ST_SEG_RD;
        end
      end
      rgas_pkg::ST_NB_CHK: begin
        // known node: keep its h, update only on a strictly cheaper route
        if (tent_r < {1'b0, rec_q.cost}) rec_we = 1'b1;
        if (seg_last) begin
          idx_nxt = '0;
          state_nxt = rgas_pkg::ST_SEL_OPEN;
        end else begin
          seg_nxt = seg_r + SCW'(1);
          state_nxt = rgas_pkg::ST_SEG_RD;
        end
      end
      rgas_pkg::ST_NB_POS: begin
        heur_req.start = 1'b1;
        state_nxt = rgas_pkg::ST_NB_H;
      end
      rgas_pkg::ST_NB_H: begin
        if (heur_rsp.done) begin
          rec_we = 1'b1;
          rec_wd.h = heur_rsp.h;
          valid_nxt[nb_r] = 1'b1;
          if (open_count_r < NCW'(MAX_NODES)) begin
            open_we = 1'b1;
            open_wa = open_count_r[NIW-1:0];
            open_wd = nb_r;
            open_count_nxt = open_count_r + NCW'(1);
          end
          if (seg_last) begin
            idx_nxt = '0;
            state_nxt = rgas_pkg::ST_SEL_OPEN;
          end else begin
            seg_nxt = seg_r + SCW'(1);
            state_nxt = rgas_pkg::ST_SEG_RD;
          end
        end
      end
      rgas_pkg::ST_BT_RD: begin
        rec_re = 1'b1;
        rec_ra = bt_node_r;
        state_nxt = rgas_pkg::ST_BT_CHK;
      end
      rgas_pkg::ST_BT_CHK: begin
        if (rec_q.parent[6]) begin
          if (path_n_r == '0) begin
            status_nxt = rgas_pkg::STATUS_EMPTY;
            state_nxt = rgas_pkg::ST_STATUS;
          end else begin
            emit_nxt = path_n_r - NCW'(1);
            state_nxt = rgas_pkg::ST_EMIT_RD;
          end
        end else begin
          // segments collected goal to start, emitted in reverse
          pb_we = 1'b1;
          path_n_nxt = path_n_r + NCW'(1);
          bt_node_nxt = rec_q.parent[NIW-1:0];
          if ((path_n_r + NCW'(1)) < NCW'(MAX_NODES - 1)) begin
            state_nxt = rgas_pkg::ST_BT_RD;
          end else begin
            emit_nxt = path_n_r;
            state_nxt = rgas_pkg::ST_EMIT_RD;
          end
        end
      end
      rgas_pkg::ST_EMIT_RD: begin
        pb_re = 1'b1;
        state_nxt = rgas_pkg::ST_EMIT_OUT;
      end
      rgas_pkg::ST_EMIT_OUT: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_seg_nxt = pb_q;
          out_status_nxt = rgas_pkg::STATUS_SEG;
          out_last_nxt = (emit_r == '0);
          if (emit_r == '0) begin
            state_nxt = rgas_pkg::ST_IDLE;
          end else begin
            emit_nxt = emit_r - NCW'(1);
            state_nxt = rgas_pkg::ST_EMIT_RD;
          end
        end
      end
      rgas_pkg::ST_STATUS: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_seg_nxt = '0;
          out_status_nxt = status_r;
          out_last_nxt = 1'b1;
          state_nxt = rgas_pkg::ST_IDLE;
        end
      end
      default: state_nxt = rgas_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= rgas_pkg::ST_IDLE;
      used_r <= '0;
      valid_r <= '0;
      open_count_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      used_r <= used_nxt;
      valid_r <= valid_nxt;
      open_count_r <= open_count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r <= idx_nxt;
    best_idx_r <= best_idx_nxt;
    best_f_r <= best_f_nxt;
    best_node_r <= best_node_nxt;
    node_tmp_r <= node_tmp_nxt;
    cur_r <= cur_nxt;
    start_r <= start_nxt;
    goal_r <= goal_nxt;
    goal_pos_r <= goal_pos_nxt;
    cost_cur_r <= cost_cur_nxt;
    seg_r <= seg_nxt;
    nb_r <= nb_nxt;
    tent_r <= tent_nxt;
    path_n_r <= path_n_nxt;
    bt_node_r <= bt_node_nxt;
    emit_r <= emit_nxt;
    status_r <= status_nxt;
    out_seg_r <= out_seg_nxt;
    out_status_r <= out_status_nxt;
    out_last_r <= out_last_nxt;
  end

`ifndef ASSERT_OFF
  a_open_bound: assert property (@(posedge clk) disable iff (!rst_n)
    open_count_r <= NCW'(MAX_NODES))
    else $error("open list count above node count");

  a_heur_wait: assert property (@(posedge clk) disable iff (!rst_n)
    heur_rsp.done |-> (state_r == rgas_pkg::ST_START_H || state_r == rgas_pkg::ST_NB_H))
    else $error("heuristic result with no search waiting for it");

  a_status_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_status_r != rgas_pkg::STATUS_SEG) |-> out_last_r)
    else $error("status result not marked last");

  a_idle_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == rgas_pkg::ST_EMIT_OUT && out_free && emit_r == '0) |=>
      state_r == rgas_pkg::ST_IDLE)
    else $error("search did not end after final path segment");
`endif

endmodule

>>> sim/tb_road_graph_a_star_path.sv
`timescale 1ns / 1ps

module tb_road_graph_a_star_path;

  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam int WATCHDOG_LIMIT = 200000;
  localparam int DRAIN_CYCLES = 100;
  localparam int LONG_HOLD = 3000;

  typedef struct {
    logic [1:0]         op;
    logic [5:0]         node;
    logic signed [30:0] x;
    logic signed [30:0] y;
    logic signed [30:0] z;
    logic [7:0]         slot;
    logic [5:0]         from_n;
    logic [5:0]         to_n;
    logic               two_way;
    logic [23:0]        weight;
    logic [5:0]         goal;
  } request_t;

  typedef struct {
    logic [7:0] seg;
    logic [1:0] status;
    logic       last;
  } path_step_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  rgas_in_if  in_chan();
  rgas_out_if out_chan();
  rgas_cfg_if cfg_chan();

  road_graph_a_star_path dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_chan(in_chan),
    .out_chan(out_chan),
    .cfg_chan(cfg_chan)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  request_t   pending[$];
  path_step_t expected_steps[$];
  int errors = 0;
  int results_seen = 0;
  int quiet_cycles = 0;
  bit took = 0;

  // mirror of the block's tables and search records
  logic signed [30:0] pos_x_m[64], pos_y_m[64], pos_z_m[64];
  logic [5:0]  seg_from_m[256], seg_to_m[256];
  logic        seg_two_way_m[256];
  logic [23:0] seg_weight_m[256];
  logic [8:0]  seg_used_m = 0;
  bit          rec_ok[64];
  logic [31:0] g_cost[64];
  logic [63:0] h_est[64];
  logic [6:0]  par[64];
  logic [7:0]  via[64];

  function automatic logic [63:0] int_sqrt(logic [63:0] v);
    logic [63:0] res, b;
    res = 0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= res + b) begin
        v = v - (res + b);
        res = (res >> 1) + b;
      end else begin
        res = res >> 1;
      end
      b = b >> 2;
    end
    return res;
  endfunction

  function automatic logic [63:0] distance(int n, int g);
    longint dx, dy, dz;
    logic [63:0] s;
    dx = longint'(pos_x_m[n]) - longint'(pos_x_m[g]);
    dy = longint'(pos_y_m[n]) - longint'(pos_y_m[g]);
    dz = longint'(pos_z_m[n]) - longint'(pos_z_m[g]);
    s = 64'(dx * dx) + 64'(dy * dy) + 64'(dz * dz);
    return int_sqrt(s);
  endfunction

  function automatic void push_step(logic [7:0] seg, logic [1:0] st, logic last);
    path_step_t r;
    r.seg = seg;
    r.status = st;
    r.last = last;
    expected_steps.push_back(r);
  endfunction

  function automatic void predict_route(int start, int goal);
    int used, best, cur, nb, cnt, n, node;
    int ord[64];
    int rev[64];
    logic [31:0] tent;
    logic [63:0] fa, fb;
    used = (seg_used_m > 256) ? 256 : int'(seg_used_m);
    foreach (rec_ok[i]) rec_ok[i] = 0;
    rec_ok[start] = 1;
    g_cost[start] = 0;
    h_est[start] = distance(start, goal);
    par[start] = rgas_pkg::NO_PARENT;
    via[start] = 0;
    ord[0] = start;
    cnt = 1;
    while (cnt > 0) begin
      best = 0;
      for (int i = 1; i < cnt; i++) begin
        fa = {32'b0, g_cost[ord[i]]} + h_est[ord[i]];
        fb = {32'b0, g_cost[ord[best]]} + h_est[ord[best]];
        if (fa < fb) best = i;
      end
      cur = ord[best];
      for (int i = best; i + 1 < cnt; i++) ord[i] = ord[i + 1];
      cnt--;
      if (cur == goal) begin
        if (par[cur][6]) begin
          push_step(8'd0, rgas_pkg::STATUS_EMPTY, 1'b1);
          return;
        end
        n = 0;
        node = cur;
        while (!par[node][6] && n < 63) begin
          rev[n] = via[node];
          n++;
          node = par[node][5:0];
        end
        for (int k = 0; k < n; k++)
          push_step(8'(rev[n - 1 - k]), rgas_pkg::STATUS_SEG, k + 1 == n);
        return;
      end
      for (int s = 0; s < used; s++) begin
        if (seg_from_m[s] == cur) nb = seg_to_m[s];
        else if (seg_two_way_m[s] && seg_to_m[s] == cur) nb = seg_from_m[s];
        else continue;
        tent = g_cost[cur] + {8'b0, seg_weight_m[s]};
        if (rec_ok[nb]) begin
          if (tent >= g_cost[nb]) continue;
        end else begin
          rec_ok[nb] = 1;
          if (cnt < 64) begin
            ord[cnt] = nb;
            cnt++;
          end
        end
        par[nb] = 7'(cur);
        via[nb] = 8'(s);
        g_cost[nb] = tent;
        h_est[nb] = distance(nb, goal);
      end
    end
    push_step(8'd0, rgas_pkg::STATUS_NONE, 1'b1);
  endfunction

  function automatic void apply_request(request_t r);
    case (r.op)
      rgas_pkg::OP_NODE: begin
        pos_x_m[r.node] = r.x;
        pos_y_m[r.node] = r.y;
        pos_z_m[r.node] = r.z;
      end
      rgas_pkg::OP_SEG: begin
        seg_from_m[r.slot] = r.from_n;
        seg_to_m[r.slot] = r.to_n;
        seg_two_way_m[r.slot] = r.two_way;
        seg_weight_m[r.slot] = r.weight;
      end
      rgas_pkg::OP_FIND: predict_route(r.node, r.goal);
      default: ;
    endcase
  endfunction

  // request source, moves on falling edges
  int burst_left = 0;
  int gap_left = 0;
  always @(negedge clk) begin
    if (!rst_n) begin
      in_chan.valid <= 1'b0;
    end else if (!(in_chan.valid && !took)) begin
      if (gap_left > 0) begin
        gap_left--;
        in_chan.valid <= 1'b0;
      end else if (pending.size() > 0) begin
        in_chan.valid <= 1'b1;
        in_chan.operation <= pending[0].op;
        in_chan.node_index <= pending[0].node;
        in_chan.pos_x <= pending[0].x;
        in_chan.pos_y <= pending[0].y;
        in_chan.pos_z <= pending[0].z;
        in_chan.seg_index <= pending[0].slot;
        in_chan.seg_from <= pending[0].from_n;
        in_chan.seg_to <= pending[0].to_n;
        in_chan.two_way <= pending[0].two_way;
        in_chan.seg_weight <= pending[0].weight;
        in_chan.goal_node <= pending[0].goal;
        if (burst_left > 0) begin
          burst_left--;
        end else begin
          burst_left = $urandom_range(0, 15);
          gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
        end
      end else begin
        in_chan.valid <= 1'b0;
      end
    end
    took = 0;
  end

  // result sink stall pattern, with one long hold-off
  int hold_left = 0;
  bit hold_done = 0;
  int stretch_left = 0;
  int stall_mode = 0;
  always @(negedge clk) begin
    if (hold_left > 0) begin
      hold_left--;
      out_chan.ready <= 1'b0;
    end else if (!hold_done && results_seen >= 15) begin
      hold_done = 1;
      hold_left = LONG_HOLD;
      out_chan.ready <= 1'b0;
    end else begin
      if (stretch_left == 0) begin
        stretch_left = $urandom_range(20, 200);
        stall_mode = $urandom_range(0, 2);
      end
      stretch_left--;
      case (stall_mode)
        0: out_chan.ready <= 1'b1;
        1: out_chan.ready <= ($urandom_range(0, 3) != 0);
        default: out_chan.ready <= $urandom_range(0, 1);
      endcase
    end
  end

  // request acceptance, result checking and watchdog
  always @(posedge clk) begin
    path_step_t e;
    bit moved;
    moved = 0;
    if (rst_n && in_chan.valid && in_chan.ready) begin
      apply_request(pending.pop_front());
      took = 1;
      moved = 1;
    end
    if (rst_n && cfg_chan.valid && cfg_chan.ready) begin
      seg_used_m = cfg_chan.data;
      moved = 1;
    end
    if (rst_n && out_chan.valid && out_chan.ready) begin
      moved = 1;
      results_seen++;
      if (expected_steps.size() == 0) begin
        $error("unexpected result seg=%0d status=%0d last=%0d",
               out_chan.path_segment, out_chan.status, out_chan.last);
        errors++;
      end else begin
        e = expected_steps.pop_front();
        if (out_chan.path_segment !== e.seg) begin
          $error("path_segment expected %0d got %0d", e.seg, out_chan.path_segment);
          errors++;
        end
        if (out_chan.status !== e.status) begin
          $error("status expected %0d got %0d", e.status, out_chan.status);
          errors++;
        end
        if (out_chan.last !== e.last) begin
          $error("last expected %0d got %0d", e.last, out_chan.last);
          errors++;
        end
      end
    end
    quiet_cycles = moved ? 0 : quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("tb_road_graph_a_star_path NOT OK");
      $finish;
    end
  end

  function automatic logic signed [30:0] rand_pos();
    if ($urandom_range(0, 7) == 0) return 31'($urandom);
    return 31'($signed($urandom_range(0, 2000)) - 1000);
  endfunction

  function automatic request_t noise_request(logic [1:0] op);
    request_t r;
    r.op = op;
    r.node = 6'($urandom);
    r.x = 31'($urandom);
    r.y = 31'($urandom);
    r.z = 31'($urandom);
    r.slot = 8'($urandom);
    r.from_n = 6'($urandom);
    r.to_n = 6'($urandom);
    r.two_way = 1'($urandom);
    r.weight = 24'($urandom);
    r.goal = 6'($urandom);
    return r;
  endfunction

  task automatic queue_node(int n, logic signed [30:0] x, logic signed [30:0] y,
                            logic signed [30:0] z);
    request_t r;
    r = noise_request(rgas_pkg::OP_NODE);
    r.node = 6'(n);
    r.x = x;
    r.y = y;
    r.z = z;
    pending.push_back(r);
  endtask

  task automatic queue_segment(int s, int f, int t, bit tw, logic [23:0] w);
    request_t r;
    r = noise_request(rgas_pkg::OP_SEG);
    r.slot = 8'(s);
    r.from_n = 6'(f);
    r.to_n = 6'(t);
    r.two_way = tw;
    r.weight = w;
    pending.push_back(r);
  endtask

  task automatic queue_route(int s, int g);
    request_t r;
    r = noise_request(rgas_pkg::OP_FIND);
    r.node = 6'(s);
    r.goal = 6'(g);
    pending.push_back(r);
  endtask

  task automatic wait_idle();
    wait (pending.size() == 0 && expected_steps.size() == 0 && !in_chan.valid);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_seg_count(int v);
    @(negedge clk);
    cfg_chan.valid <= 1'b1;
    cfg_chan.data <= 9'(v);
    do @(posedge clk); while (!cfg_chan.ready);
    @(negedge clk);
    cfg_chan.valid <= 1'b0;
  endtask

  function automatic logic [23:0] rand_weight();
    if ($urandom_range(0, 9) == 0) return 24'($urandom);
    return 24'($urandom_range(0, 5000));
  endfunction

  initial begin
    int used;
    in_chan.valid = 1'b0;
    in_chan.operation = rgas_pkg::OP_NODE;
    in_chan.node_index = '0;
    in_chan.pos_x = '0;
    in_chan.pos_y = '0;
    in_chan.pos_z = '0;
    in_chan.seg_index = '0;
    in_chan.seg_from = '0;
    in_chan.seg_to = '0;
    in_chan.two_way = 1'b0;
    in_chan.seg_weight = '0;
    in_chan.goal_node = '0;
    out_chan.ready = 1'b0;
    cfg_chan.valid = 1'b0;
    cfg_chan.data = '0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed: extreme positions and weights, ignored operation, empty and missing paths
    write_seg_count(0);
    queue_node(0, 31'sh3FFFFFFF, 31'sh3FFFFFFF, 31'sh3FFFFFFF);
    queue_node(1, -31'sh40000000, -31'sh40000000, -31'sh40000000);
    queue_node(2, 31'sd0, 31'sd0, 31'sd0);
    queue_node(63, 31'sd17, -31'sd5, 31'sd900);
    pending.push_back(noise_request(OP_UNUSED));
    queue_route(0, 0);
    queue_route(0, 1);
    queue_segment(0, 0, 1, 0, 24'd0);
    queue_segment(1, 1, 2, 1, 24'hFFFFFF);
    queue_segment(2, 2, 63, 0, 24'd5);
    queue_segment(255, 63, 0, 1, 24'd1);
    wait_idle();
    write_seg_count(3);
    queue_route(0, 2);
    queue_route(2, 1);
    queue_route(1, 0);
    queue_route(63, 0);
    queue_route(0, 63);
    queue_route(63, 63);
    pending.push_back(noise_request(OP_UNUSED));

    // fill the node and segment slots used below, then search three random routes over them
    for (int n = 0; n < 32; n++) queue_node(n, rand_pos(), rand_pos(), rand_pos());
    for (int s = 0; s < 64; s++)
      queue_segment(s, $urandom_range(0, 31), $urandom_range(0, 31), $urandom_range(0, 1),
                    rand_weight());
    wait_idle();
    write_seg_count(64);
    for (int i = 0; i < 3; i++) queue_route($urandom_range(0, 31), $urandom_range(0, 31));

    // random phases over small segment counts
    for (int p = 0; p < 7; p++) begin
      wait_idle();
      case (p)
        0: used = 0;
        1: used = 1;
        2: used = 64;
        default: used = $urandom_range(8, 48);
      endcase
      write_seg_count(used);
      for (int i = 0; i < 8; i++) begin
        case ($urandom_range(0, 9))
          0: queue_segment($urandom_range(0, 63), $urandom_range(0, 31),
                           $urandom_range(0, 31), $urandom_range(0, 1), rand_weight());
          1: queue_node($urandom_range(0, 31), rand_pos(), rand_pos(), rand_pos());
          2: pending.push_back(noise_request(OP_UNUSED));
          3: begin
            used = $urandom_range(0, 31);
            queue_route(used, used);
          end
          default: queue_route($urandom_range(0, 31), $urandom_range(0, 31));
        endcase
        if (p == 2 && i == 3) break;
      end
    end

    wait_idle();
    if (errors == 0) begin
      $display("tb_road_graph_a_star_path OK");
    end else begin
      $display("tb_road_graph_a_star_path NOT OK");
    end
    $finish;
  end

endmodule

>>> road_graph_a_star_path.f
design/rgas_pkg.sv
design/rgas_if.sv
design/rgas_heur.sv
design/road_graph_a_star_path.sv
sim/tb_road_graph_a_star_path.sv
